[rtl/dfmt_pkg.sv]
`default_nettype none

package dfmt_pkg;

    // field geometry
    localparam int MAX_WIDTH   = 16;
    localparam int NATURAL_LEN = 6;
    localparam int MAX_DIGITS  = 5;

    // counter widths
    localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
    localparam int DIDX_W = $clog2(MAX_DIGITS);
    localparam int ND_W   = $clog2(MAX_DIGITS + 1);

    // input and output field widths
    localparam int MAG_W  = 16;
    localparam int FW_W   = 5;
    localparam int CHAR_W = 8;

    // divide by ten through a reciprocal, exact for every 16-bit value
    localparam int           DIV10_SHIFT = 19;
    localparam logic [16:0]  DIV10_MUL   = 17'd52429;
    localparam int           PROD_W      = MAG_W + 17;
    localparam int           QUOT_W      = MAG_W - 3;

    // character codes
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_STAR  = 8'h2A;

    typedef logic [WCNT_W-1:0] t_cnt;
    typedef logic [DIDX_W-1:0] t_didx;
    typedef logic [ND_W-1:0]   t_nd;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic conv;
        logic setup;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic conv_done;
        logic out_free;
        logic at_last;
    } t_status;

endpackage

`default_nettype wire

[rtl/dfmt_ctrl.sv]
`default_nettype none

module dfmt_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire dfmt_pkg::t_status i_status,
    output dfmt_pkg::t_cmd        o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CONV  = 4'b0010,
        ST_SETUP = 4'b0100,
        ST_EMIT  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_ready     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CONV;
                end
            end
            ST_CONV: begin
                o_cmd.conv = 1'b1;
                if (i_status.conv_done) begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.at_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/dfmt_datapath.sv]
`default_nettype none

module dfmt_datapath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire dfmt_pkg::t_cmd                i_cmd,
    output dfmt_pkg::t_status                  o_status,
    input  wire logic [dfmt_pkg::MAG_W-1:0]    i_magnitude,
    input  wire logic                          i_is_negative,
    input  wire logic [dfmt_pkg::FW_W-1:0]     i_field_width,
    input  wire logic [dfmt_pkg::CHAR_W-1:0]   i_pad_char,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [dfmt_pkg::CHAR_W-1:0]        o_text_char,
    output logic                               o_last_char
);

    // captured word
    logic [dfmt_pkg::MAG_W-1:0]  r_mag;
    logic                        r_neg;
    dfmt_pkg::t_cnt              r_w;
    logic [dfmt_pkg::CHAR_W-1:0] r_pad;

    // digit store, least significant first
    logic [3:0]                  r_digs [dfmt_pkg::MAX_DIGITS];
    dfmt_pkg::t_nd               r_nd;

    // emit plan
    dfmt_pkg::t_cnt              r_total;
    dfmt_pkg::t_cnt              r_pad_cnt;
    logic                        r_ovf;
    dfmt_pkg::t_cnt              r_pos;

    // output register
    logic                        r_out_valid;
    logic [dfmt_pkg::CHAR_W-1:0] r_out_char;
    logic                        r_out_last;

    dfmt_pkg::t_cnt              w_clamp;
    logic [dfmt_pkg::PROD_W-1:0] prod;
    logic [dfmt_pkg::QUOT_W-1:0] quot;
    logic [dfmt_pkg::MAG_W-1:0]  quot_x10;
    logic [3:0]                  digit;
    dfmt_pkg::t_cnt              tlen;
    dfmt_pkg::t_cnt              flen;
    logic                        ovf;
    dfmt_pkg::t_cnt              rem;
    dfmt_pkg::t_didx             didx;
    logic [3:0]                  dsel;
    logic [dfmt_pkg::CHAR_W-1:0] ch;

    // width saturation
    always_comb begin
        if (32'(i_field_width) > 32'(dfmt_pkg::MAX_WIDTH)) begin
            w_clamp = dfmt_pkg::t_cnt'(dfmt_pkg::MAX_WIDTH);
        end else begin
            w_clamp = dfmt_pkg::t_cnt'(i_field_width);
        end
    end

    // one decimal digit per cycle
    assign prod     = dfmt_pkg::PROD_W'(r_mag) * dfmt_pkg::PROD_W'(dfmt_pkg::DIV10_MUL);
    assign quot     = prod[dfmt_pkg::DIV10_SHIFT +: dfmt_pkg::QUOT_W];
    assign quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
    assign digit    = 4'(r_mag - quot_x10);

    // field plan
    assign tlen = dfmt_pkg::t_cnt'(r_nd) + dfmt_pkg::t_cnt'(r_neg);
    assign flen = (r_w == '0) ? dfmt_pkg::t_cnt'(dfmt_pkg::NATURAL_LEN) : r_w;
    assign ovf  = tlen > flen;

    // character at the current position
    assign rem  = r_total - r_pos - dfmt_pkg::t_cnt'(1);
    assign didx = rem[dfmt_pkg::DIDX_W-1:0];
    always_comb begin
        if (32'(didx) < dfmt_pkg::MAX_DIGITS) begin
            dsel = r_digs[didx];
        end else begin
            dsel = '0;
        end
        if (r_ovf) begin
            ch = dfmt_pkg::CHAR_STAR;
        end else if (r_pos < r_pad_cnt) begin
            ch = r_pad;
        end else if (r_neg && (r_pos == r_pad_cnt)) begin
            ch = dfmt_pkg::CHAR_MINUS;
        end else begin
            ch = dfmt_pkg::CHAR_ZERO + {4'b0000, dsel};
        end
    end

    // status
    assign o_status.conv_done = (quot == '0) ||
                                (r_nd == dfmt_pkg::t_nd'(dfmt_pkg::MAX_DIGITS - 1));
    assign o_status.out_free  = !r_out_valid || i_ready;
    assign o_status.at_last   = (r_pos == r_total - dfmt_pkg::t_cnt'(1));

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag <= i_magnitude;
            r_neg <= i_is_negative;
            r_w   <= w_clamp;
            r_pad <= i_pad_char;
            r_nd  <= '0;
        end
        if (i_cmd.conv) begin
            r_digs[r_nd[dfmt_pkg::DIDX_W-1:0]] <= digit;
            r_mag <= dfmt_pkg::MAG_W'(quot);
            r_nd  <= r_nd + dfmt_pkg::t_nd'(1);
        end
        if (i_cmd.setup) begin
            r_ovf <= ovf;
            r_pos <= '0;
            if (ovf || (r_w != '0)) begin
                r_total <= flen;
            end else begin
                r_total <= tlen;
            end
            if (!ovf && (r_w != '0)) begin
                r_pad_cnt <= flen - tlen;
            end else begin
                r_pad_cnt <= '0;
            end
        end
        if (i_cmd.emit) begin
            r_pos      <= r_pos + dfmt_pkg::t_cnt'(1);
            r_out_char <= ch;
            r_out_last <= o_status.at_last;
        end
    end

    // output word valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_text_char = r_out_char;
    assign o_last_char = r_out_last;

`ifndef ASSERT_OFF
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_ready))
        else $error("word emitted over a held output word");
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (r_pos < r_total))
        else $error("emit position beyond field length");
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.conv |-> (digit < 4'd10))
        else $error("digit out of decimal range");
    a_nd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.conv |-> (32'(r_nd) < dfmt_pkg::MAX_DIGITS))
        else $error("digit count overflow");
`endif

endmodule

`default_nettype wire

[rtl/decimal_field_formatter_core.sv]
`default_nettype none

// channel   direction  handshake          payload
// input     in         i_valid / o_ready  i_magnitude, i_is_negative, i_field_width, i_pad_char
// output    out        o_valid / i_ready  o_text_char, o_last_char
//
// each item is accepted, converted one decimal digit at a time (1 to 5)
// through the shared divide-by-ten multiplier, planned, then sent one
// character at a time (up to 16) from the output register while i_ready stays high.
// i_rst_n is synchronous and clears the controller and the output valid.
// a stalled output holds its word; the next item is taken while the last
// character of the previous field still waits in the output register.

module decimal_field_formatter_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [dfmt_pkg::MAG_W-1:0]  i_magnitude,
    input  wire logic                        i_is_negative,
    input  wire logic [dfmt_pkg::FW_W-1:0]   i_field_width,
    input  wire logic [dfmt_pkg::CHAR_W-1:0] i_pad_char,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [dfmt_pkg::CHAR_W-1:0]      o_text_char,
    output logic                             o_last_char
);

    dfmt_pkg::t_cmd    cmd;
    dfmt_pkg::t_status status;

    // sequencer
    dfmt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // conversion and output datapath
    dfmt_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_magnitude   (i_magnitude),
        .i_is_negative (i_is_negative),
        .i_field_width (i_field_width),
        .i_pad_char    (i_pad_char),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_text_char   (o_text_char),
        .o_last_char   (o_last_char)
    );

endmodule

`default_nettype wire
